[src/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the scan-line polygon span tables.
// ----------------------------------------------------------------------------
package spt_pkg;

  // Coordinate and table geometry.
  localparam int COORD_W   = 9;
  localparam int FRAC_BITS = 16;
  localparam int ROWS      = 512;
  localparam int XLIMIT    = 512;
  localparam int ADDR_W    = $clog2(ROWS);
  localparam int LEFT_W    = $clog2(XLIMIT + 1);
  localparam int RIGHT_W   = COORD_W;
  localparam int ENTRY_W   = LEFT_W + RIGHT_W;

  // Walking x: sign bit, integer part and fraction.
  localparam int XF_W      = COORD_W + FRAC_BITS + 1;

  // Slope divider: one quotient bit per cycle.
  localparam int DIV_STEPS = COORD_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Stream widths.
  localparam int S_FIELDS_W = 5 * COORD_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = LEFT_W + RIGHT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } spt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic div_step;
    logic walk_step;
    logic q_read;
    logic res_zero;
    logic res_query;
  } spt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic walk_last;
    logic flat;
    logic wr_pend;
    logic res_busy;
  } spt_stat_t;

endpackage

[src/spt_ram.sv]
// ----------------------------------------------------------------------------
// spt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/spt_datapath.sv]
// ----------------------------------------------------------------------------
// spt_datapath
// Edge setup, slope divider, row walker, bound table and result register.
// ----------------------------------------------------------------------------
module spt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spt_pkg::spt_cmd_t             cmd_i,
  output spt_pkg::spt_stat_t            stat_o,
  input  logic [spt_pkg::OP_W-1:0]      op_i,
  input  logic [spt_pkg::COORD_W-1:0]   x_start_i,
  input  logic [spt_pkg::COORD_W-1:0]   y_start_i,
  input  logic [spt_pkg::COORD_W-1:0]   x_end_i,
  input  logic [spt_pkg::COORD_W-1:0]   y_end_i,
  input  logic [spt_pkg::COORD_W-1:0]   row_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic [spt_pkg::LEFT_W-1:0]    res_left_o,
  output logic [spt_pkg::RIGHT_W-1:0]   res_right_o,
  output logic                          res_flag_o
);

  localparam int CW = spt_pkg::COORD_W;
  localparam int FB = spt_pkg::FRAC_BITS;
  localparam int XW = spt_pkg::XF_W;
  localparam int DS = spt_pkg::DIV_STEPS;

  // Edge setup from the request fields.
  logic          swap;
  logic [CW-1:0] x_lo, x_hi, y_lo, y_hi;
  logic          x_neg;
  logic [CW-1:0] dx_mag;

  // Registers.
  logic [CW-1:0]                   y_d, y_q;
  logic [CW-1:0]                   y_hi_q;
  logic [CW-1:0]                   row_q;
  logic [XW-1:0]                   x_q;
  logic                            neg_q;
  logic [CW-1:0]                   den_q;
  logic [CW-1:0]                   rem_q;
  logic [DS-1:0]                   quo_q;
  logic [spt_pkg::DIV_CNT_W-1:0]   div_cnt_q;
  logic                            wr_pend_q;
  logic [CW-1:0]                   wr_addr_q;
  logic [CW-1:0]                   wr_x_q;
  logic                            res_valid_q;
  logic [spt_pkg::LEFT_W-1:0]      res_left_q;
  logic [spt_pkg::RIGHT_W-1:0]     res_right_q;
  logic                            res_flag_q;

  // Divider step.
  logic [CW:0]   rem_shift;
  logic [CW:0]   rem_diff;

  // Walk arithmetic.
  logic [XW-1:0] quo_ext;
  logic [CW-1:0] x_int;

  // Table port.
  logic                                ram_we;
  logic [spt_pkg::ADDR_W-1:0]          ram_waddr;
  logic [spt_pkg::ENTRY_W-1:0]         ram_wdata;
  logic                                ram_re;
  logic [spt_pkg::ADDR_W-1:0]          ram_raddr;
  logic [spt_pkg::ENTRY_W-1:0]         ram_rdata;
  logic [spt_pkg::LEFT_W-1:0]          rd_left, new_left, x_int_wide;
  logic [spt_pkg::RIGHT_W-1:0]         rd_right, new_right;

  assign swap   = (y_end_i < y_start_i);
  assign x_lo   = swap ? x_end_i   : x_start_i;
  assign x_hi   = swap ? x_start_i : x_end_i;
  assign y_lo   = swap ? y_end_i   : y_start_i;
  assign y_hi   = swap ? y_start_i : y_end_i;
  assign x_neg  = (x_hi < x_lo);
  assign dx_mag = x_neg ? (x_lo - x_hi) : (x_hi - x_lo);

  assign rem_shift = {rem_q, quo_q[DS-1]};
  assign rem_diff  = rem_shift - {1'b0, den_q};

  assign quo_ext = {{(XW-DS){1'b0}}, quo_q};
  // The walk never goes negative, but a negative x clamps to zero.
  assign x_int   = x_q[XW-1] ? '0 : x_q[XW-2:FB];

  always_comb begin
    y_d = y_q;
    if (cmd_i.load) begin
      y_d = (spt_pkg::spt_op_e'(op_i) == spt_pkg::OP_CLEAR) ? '0 : y_lo;
    end else if (cmd_i.clr_step || cmd_i.walk_step) begin
      y_d = y_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q         <= '0;
      div_cnt_q   <= '0;
      wr_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      y_q       <= y_d;
      wr_pend_q <= cmd_i.walk_step;
      if (cmd_i.load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + spt_pkg::DIV_CNT_W'(1);
      end
      if (cmd_i.res_zero || cmd_i.res_query) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      y_hi_q <= y_hi;
      row_q  <= row_i;
      neg_q  <= x_neg;
      den_q  <= y_hi - y_lo;
      rem_q  <= '0;
      quo_q  <= {dx_mag, {FB{1'b0}}};
      x_q    <= {1'b0, x_lo, {FB{1'b0}}};
    end else if (cmd_i.div_step) begin
      if (!rem_diff[CW]) begin
        rem_q <= rem_diff[CW-1:0];
        quo_q <= {quo_q[DS-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[CW-1:0];
        quo_q <= {quo_q[DS-2:0], 1'b0};
      end
    end else if (cmd_i.walk_step) begin
      x_q <= neg_q ? (x_q - quo_ext) : (x_q + quo_ext);
    end
    if (cmd_i.walk_step) begin
      wr_addr_q <= y_q;
      wr_x_q    <= x_int;
    end
    if (cmd_i.res_zero) begin
      res_left_q  <= '0;
      res_right_q <= '0;
      res_flag_q  <= 1'b0;
    end else if (cmd_i.res_query) begin
      res_left_q  <= rd_left;
      res_right_q <= rd_right;
      res_flag_q  <= ({1'b0, rd_right} >= rd_left);
    end
  end

  // Bound update in the cycle after the row was read.
  assign rd_left    = ram_rdata[spt_pkg::LEFT_W-1:0];
  assign rd_right   = ram_rdata[spt_pkg::ENTRY_W-1:spt_pkg::LEFT_W];
  assign x_int_wide = {{(spt_pkg::LEFT_W-CW){1'b0}}, wr_x_q};
  assign new_left   = (x_int_wide < rd_left) ? x_int_wide : rd_left;
  assign new_right  = (wr_x_q > rd_right) ? wr_x_q : rd_right;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q[spt_pkg::ADDR_W-1:0];
    ram_wdata = {new_right, new_left};
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = y_q[spt_pkg::ADDR_W-1:0];
      ram_wdata = {{spt_pkg::RIGHT_W{1'b0}}, spt_pkg::LEFT_W'(spt_pkg::XLIMIT)};
    end else if (wr_pend_q) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = cmd_i.walk_step || cmd_i.q_read;
  assign ram_raddr = cmd_i.q_read ? row_q[spt_pkg::ADDR_W-1:0]
                                  : y_q[spt_pkg::ADDR_W-1:0];

  spt_ram #(
    .WIDTH (spt_pkg::ENTRY_W),
    .DEPTH (spt_pkg::ROWS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.clr_last  = (y_q == CW'(spt_pkg::ROWS - 1));
  assign stat_o.div_done  = (div_cnt_q == spt_pkg::DIV_CNT_W'(DS - 1));
  assign stat_o.walk_last = (y_q == y_hi_q);
  assign stat_o.flat      = (y_start_i == y_end_i);
  assign stat_o.wr_pend   = wr_pend_q;
  assign stat_o.res_busy  = res_valid_q && !res_ready_i;

  assign res_valid_o = res_valid_q;
  assign res_left_o  = res_left_q;
  assign res_right_o = res_right_q;
  assign res_flag_o  = res_flag_q;

endmodule

[src/spt_ctrl.sv]
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer for table clears, slope division, row walks and queries.
// ----------------------------------------------------------------------------
module spt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  logic [spt_pkg::OP_W-1:0] op_i,
  output logic                     req_ready_o,
  input  spt_pkg::spt_stat_t       stat_i,
  output spt_pkg::spt_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_WALK,
    S_QREAD,
    S_QDATA,
    S_DONE
  } state_e;

  state_e state_d, state_q;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.load = accept;
        if (accept) begin
          case (spt_pkg::spt_op_e'(op_i))
            spt_pkg::OP_CLEAR: state_d = S_CLEAR;
            spt_pkg::OP_ADD:   state_d = stat_i.flat ? S_WALK : S_DIV;
            spt_pkg::OP_QUERY: state_d = S_QREAD;
            default:           state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_DONE;
        end
      end
      S_QREAD: begin
        cmd_o.q_read = 1'b1;
        state_d      = S_QDATA;
      end
      S_QDATA: begin
        if (!stat_i.res_busy) begin
          cmd_o.res_query = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DONE: begin
        if (!stat_i.res_busy) begin
          cmd_o.res_zero = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/scanline_polygon_span_tables.sv]
// ----------------------------------------------------------------------------
// scanline_polygon_span_tables
// Scan-line polygon fill: per-row left/right bound tables built from edges.
// ----------------------------------------------------------------------------
// Each request is a clear, an add-edge, a row query or a no-op, and each
// one returns exactly one result; only a query returns a nonzero span.
// After reset the block sweeps all 512 rows of the bound table (one row per
// cycle) and accepts no request until that pass is over. A clear request
// runs the same sweep. An add-edge request runs a bit-serial slope divider
// (skipped for a horizontal edge), then walks one row per cycle from the
// low y to the high y inclusive. A query reads its row through the
// registered read port of the table. The table is a single RAM with one
// write and one read port; the walk reads a row and writes it back in the
// cycle after, overlapped with the read of the next row. The result sits in
// an output register, so a new request is taken while the last result waits.
// ----------------------------------------------------------------------------
module scanline_polygon_span_tables (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Requests.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27],
  //        row[44:36], zero fill up to bit 47.
  input  logic [spt_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: operation[1:0].
  input  logic [spt_pkg::OP_W-1:0]       s_axis_tuser_i,
  // Results.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: span_left[9:0], span_right[18:10], zero fill up to bit 23.
  output logic [spt_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser: span_valid[0].
  output logic [0:0]                     m_axis_tuser_o
);

  localparam int CW = spt_pkg::COORD_W;

  spt_pkg::spt_cmd_t  cmd;
  spt_pkg::spt_stat_t stat;

  logic [spt_pkg::LEFT_W-1:0]  res_left;
  logic [spt_pkg::RIGHT_W-1:0] res_right;
  logic                        res_flag;

  // The controller sequences each request; the datapath holds all data storage.
  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .op_i        (s_axis_tuser_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (s_axis_tuser_i),
    .x_start_i   (s_axis_tdata_i[CW-1:0]),
    .y_start_i   (s_axis_tdata_i[2*CW-1:CW]),
    .x_end_i     (s_axis_tdata_i[3*CW-1:2*CW]),
    .y_end_i     (s_axis_tdata_i[4*CW-1:3*CW]),
    .row_i       (s_axis_tdata_i[5*CW-1:4*CW]),
    .res_ready_i (m_axis_tready_i),
    .res_valid_o (m_axis_tvalid_o),
    .res_left_o  (res_left),
    .res_right_o (res_right),
    .res_flag_o  (res_flag)
  );

  assign m_axis_tdata_o = {{(spt_pkg::M_TDATA_W - spt_pkg::M_FIELDS_W){1'b0}},
                           res_right, res_left};
  assign m_axis_tuser_o = res_flag;

  // A table clear and a walk write-back never compete for the write port.
  a_no_write_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !stat.wr_pend)
    else $error("clear sweep collided with a pending walk write");

  // The last row of a walk is written back in the cycle after its read.
  a_last_row_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_step && stat.walk_last |=> stat.wr_pend && !cmd.walk_step)
    else $error("walk did not end with a write-back of its last row");

  // A span flagged as filled never carries the cleared left bound.
  a_valid_span_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      res_left != spt_pkg::LEFT_W'(spt_pkg::XLIMIT))
    else $error("filled span reported with an untouched left bound");

endmodule
